>>> rtl/core/qsl_pkg.sv
// ----------------------------------------------------------------------------
// qsl_pkg
// Shared types, sizes and the dequantization table for the slice decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qsl_pkg;

   localparam int CHANNELS  = 8;
   localparam int SLICE_LEN = 20;
   localparam int TAPS      = 4;

   localparam int CH_W    = 3;
   localparam int CNT_W   = 5;
   localparam int WORD_W  = 64;
   localparam int HIST_W  = 16;
   localparam int WGT_W   = 32;
   localparam int TAP_W   = 2;
   localparam int PROD_W  = HIST_W + WGT_W;
   localparam int ACC_W   = PROD_W + TAP_W;
   localparam int SHIFT   = 13;
   localparam int PRED_W  = ACC_W - SHIFT;
   localparam int REC_W   = PRED_W + 1;
   localparam int SF_W    = 4;
   localparam int CODE_W  = 3;
   localparam int CODES_W = WORD_W - SF_W;
   localparam int DELTA_SH = 4;
   localparam int DQ_MAG_W = 15;

   localparam logic signed [HIST_W-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [HIST_W-1:0] SAMPLE_MAX = 16'sh7fff;

   typedef logic [CH_W-1:0]               ch_idx_type;
   typedef logic signed [HIST_W-1:0]      hist_type;
   typedef logic signed [WGT_W-1:0]       wgt_type;
   typedef hist_type [TAPS-1:0]           hist_row_type;
   typedef wgt_type  [TAPS-1:0]           wgt_row_type;
   typedef logic signed [ACC_W-1:0]       acc_type;

   typedef enum logic [1:0] {
      MODE_LOAD_HIST = 2'd0,
      MODE_LOAD_WGT  = 2'd1,
      MODE_DECODE    = 2'd2,
      MODE_RSVD      = 2'd3
   } mode_type;

   // Row write into the predictor store.
   typedef struct packed {
      logic         hist_en;
      logic         wgt_en;
      ch_idx_type   channel;
      hist_row_type hist;
      wgt_row_type  wgt;
   } store_wr_type;

   // Controls for the shared multiply-accumulate unit.
   typedef struct packed {
      logic mul_en;
      logic clear;
      logic acc_en;
   } mac_ctl_type;

   typedef logic [DQ_MAG_W-1:0] dq_mag_type;

   localparam dq_mag_type DQ_MAG [16][4] = '{
      '{15'd1,    15'd3,    15'd5,    15'd7},
      '{15'd5,    15'd18,   15'd32,   15'd49},
      '{15'd16,   15'd53,   15'd95,   15'd147},
      '{15'd34,   15'd113,  15'd203,  15'd315},
      '{15'd63,   15'd210,  15'd378,  15'd588},
      '{15'd104,  15'd345,  15'd621,  15'd966},
      '{15'd158,  15'd528,  15'd950,  15'd1477},
      '{15'd228,  15'd760,  15'd1368, 15'd2128},
      '{15'd316,  15'd1053, 15'd1895, 15'd2947},
      '{15'd422,  15'd1405, 15'd2529, 15'd3934},
      '{15'd548,  15'd1828, 15'd3290, 15'd5117},
      '{15'd696,  15'd2320, 15'd4176, 15'd6496},
      '{15'd868,  15'd2893, 15'd5207, 15'd8099},
      '{15'd1064, 15'd3548, 15'd6386, 15'd9933},
      '{15'd1286, 15'd4288, 15'd7718, 15'd12005},
      '{15'd1536, 15'd5120, 15'd9216, 15'd14336}
   };

   // Odd codes are the negated magnitude.
   function automatic hist_type dq_lookup(input logic [SF_W-1:0] sf,
                                          input logic [CODE_W-1:0] q);
      hist_type mag;
      mag = hist_type'({1'b0, DQ_MAG[sf][q[2:1]]});
      return q[0] ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/qsl_req_if.sv
// ----------------------------------------------------------------------------
// qsl_req_if
// Request channel: mode, channel, state or slice word and sample count.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [2:0]  channel;
   logic [63:0] word;
   logic [4:0]  sample_count;

   modport source (output valid, output mode, output channel, output word,
                   output sample_count, input ready);
   modport sink   (input valid, input mode, input channel, input word,
                   input sample_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/qsl_rsp_if.sv
// ----------------------------------------------------------------------------
// qsl_rsp_if
// Response channel: one decoded PCM sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic [2:0]         out_channel;
   logic               last;

   modport source (output valid, output sample, output out_channel, output last,
                   input ready);
   modport sink   (input valid, input sample, input out_channel, input last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/qsl_store.sv
// ----------------------------------------------------------------------------
// qsl_store
// Per-channel predictor state: four history samples and four weights a row.
// ----------------------------------------------------------------------------
`default_nettype none

module qsl_store import qsl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ch_idx_type   rd_channel,
   output hist_row_type rd_hist,
   output wgt_row_type  rd_wgt,
   input  store_wr_type wr
);

   hist_row_type hist_mem_ff [CHANNELS];
   wgt_row_type  wgt_mem_ff  [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            hist_mem_ff[i] <= '0;
            wgt_mem_ff[i]  <= '0;
         end
      end else begin
         if (wr.hist_en) begin
            hist_mem_ff[wr.channel] <= wr.hist;
         end
         if (wr.wgt_en) begin
            wgt_mem_ff[wr.channel] <= wr.wgt;
         end
      end
   end

   assign rd_hist = hist_mem_ff[rd_channel];
   assign rd_wgt  = wgt_mem_ff[rd_channel];

endmodule

`default_nettype wire

>>> rtl/core/qsl_mac.sv
// ----------------------------------------------------------------------------
// qsl_mac
// Shared 32x16 multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module qsl_mac import qsl_pkg::*; (
   input  logic        clock,
   input  mac_ctl_type ctl,
   input  wgt_type     wgt,
   input  hist_type    hist,
   output acc_type     acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   acc_type                  acc_ff;
   acc_type                  acc_in;

   assign prod_in = PROD_W'(wgt) * PROD_W'(hist);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

>>> rtl/core/qoa_slice_lms_decoder.sv
// ----------------------------------------------------------------------------
// qoa_slice_lms_decoder
// Per-channel QOA slice decoder with a four-tap LMS predictor.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                 per transfer
//  req_chan  in   mode, channel, word, sample_count       one load or one slice
//  rsp_chan  out  sample, out_channel, last               one decoded sample
//
//  A load writes the store from idle. For a slice of n samples, each sample
//  runs four passes through the one shared multiplier, one accumulate, one
//  clamp and one weight/history update. The request side is ready only in idle.
//  A full output register holds the clamp step until the sample is taken.
//  Synchronous reset clears all history and weights to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module qoa_slice_lms_decoder import qsl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   qsl_req_if.sink       req_chan,
   qsl_rsp_if.source     rsp_chan
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [TAP_W-1:0]       tap_ff, tap_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   ch_idx_type             ch_ff, ch_in;
   logic [SF_W-1:0]        sf_ff, sf_in;
   logic [CODES_W-1:0]     codes_ff, codes_in;
   hist_row_type           hist_ff, hist_in;
   wgt_row_type            wgt_ff, wgt_in;
   hist_type               deq_ff, deq_in;
   hist_type               rec_ff, rec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hist_type               rsp_sample_ff, rsp_sample_in;
   ch_idx_type             rsp_ch_ff, rsp_ch_in;
   logic                   rsp_last_ff, rsp_last_in;

   store_wr_type           store_wr;
   hist_row_type           rd_hist;
   wgt_row_type            rd_wgt;
   mac_ctl_type            mac_ctl;
   acc_type                acc;

   logic                   req_xfer;
   logic                   ch_ok;
   logic [CNT_W-1:0]       cnt_sat;
   hist_row_type           ld_row;
   wgt_row_type            ld_wgt;
   hist_type               deq_cur;
   logic signed [PRED_W-1:0] pred;
   logic signed [REC_W-1:0]  rec_wide;
   hist_type               rec_clamp;
   logic                   rsp_load;
   logic                   last_sample;
   logic signed [HIST_W-DELTA_SH-1:0] delta;
   wgt_row_type            wgt_upd;
   hist_row_type           hist_upd;

   qsl_store u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_channel (req_chan.channel),
      .rd_hist    (rd_hist),
      .rd_wgt     (rd_wgt),
      .wr         (store_wr)
   );

   qsl_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .wgt   (wgt_ff[tap_ff]),
      .hist  (hist_ff[tap_ff]),
      .acc   (acc)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign ch_ok          = (32'(req_chan.channel) < CHANNELS);
   assign cnt_sat        = (req_chan.sample_count > CNT_W'(SLICE_LEN)) ?
                           CNT_W'(SLICE_LEN) : req_chan.sample_count;

   // Tap 0 sits in the top 16 bits of the load word.
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         ld_row[t] = req_chan.word[WORD_W-1-HIST_W*t -: HIST_W];
         ld_wgt[t] = WGT_W'(ld_row[t]);
      end
   end

   // Clamp path: floor shift of the prediction plus the dequantized residual.
   assign deq_cur  = dq_lookup(sf_ff, codes_ff[CODES_W-1 -: CODE_W]);
   assign pred     = acc[ACC_W-1:SHIFT];
   assign rec_wide = REC_W'(pred) + REC_W'(deq_cur);

   always_comb begin
      if (rec_wide < REC_W'(SAMPLE_MIN)) begin
         rec_clamp = SAMPLE_MIN;
      end else if (rec_wide > REC_W'(SAMPLE_MAX)) begin
         rec_clamp = SAMPLE_MAX;
      end else begin
         rec_clamp = rec_wide[HIST_W-1:0];
      end
   end

   // LMS update: sign of each history value steers the residual step.
   assign delta       = deq_ff[HIST_W-1:DELTA_SH];
   assign last_sample = (idx_ff == n_ff - CNT_W'(1));

   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         wgt_upd[t] = hist_ff[t][HIST_W-1] ? wgt_ff[t] - WGT_W'(delta)
                                           : wgt_ff[t] + WGT_W'(delta);
         hist_upd[t] = (t == TAPS - 1) ? rec_ff : hist_ff[(t + 1) % TAPS];
      end
   end

   assign rsp_load = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      ch_in         = ch_ff;
      sf_in         = sf_ff;
      codes_in      = codes_ff;
      hist_in       = hist_ff;
      wgt_in        = wgt_ff;
      deq_in        = deq_ff;
      rec_in        = rec_ff;
      mac_ctl       = '0;
      store_wr.hist_en = 1'b0;
      store_wr.wgt_en  = 1'b0;
      store_wr.channel = req_chan.channel;
      store_wr.hist    = ld_row;
      store_wr.wgt     = ld_wgt;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && ch_ok) begin
               case (mode_type'(req_chan.mode))
                  MODE_LOAD_HIST: store_wr.hist_en = 1'b1;
                  MODE_LOAD_WGT:  store_wr.wgt_en  = 1'b1;
                  MODE_DECODE: begin
                     if (cnt_sat != '0) begin
                        ch_in    = req_chan.channel;
                        n_in     = cnt_sat;
                        idx_in   = '0;
                        tap_in   = '0;
                        sf_in    = req_chan.word[WORD_W-1 -: SF_W];
                        codes_in = req_chan.word[CODES_W-1:0];
                        hist_in  = rd_hist;
                        wgt_in   = rd_wgt;
                        state_in = ST_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            mac_ctl.clear  = (tap_ff == '0);
            mac_ctl.acc_en = (tap_ff != '0);
            tap_in         = tap_ff + TAP_W'(1);
            if (tap_ff == TAP_W'(TAPS - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            mac_ctl.acc_en = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               deq_in   = deq_cur;
               rec_in   = rec_clamp;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            wgt_in   = wgt_upd;
            hist_in  = hist_upd;
            codes_in = codes_ff << CODE_W;
            idx_in   = idx_ff + CNT_W'(1);
            if (last_sample) begin
               store_wr.hist_en = 1'b1;
               store_wr.wgt_en  = 1'b1;
               store_wr.channel = ch_ff;
               store_wr.hist    = hist_upd;
               store_wr.wgt     = wgt_upd;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: load on the clamp step, drop on transfer.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = rec_clamp;
         rsp_ch_in     = ch_ff;
         rsp_last_in   = last_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         idx_ff       <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      sf_ff         <= sf_in;
      codes_ff      <= codes_in;
      hist_ff       <= hist_in;
      wgt_ff        <= wgt_in;
      deq_ff        <= deq_in;
      rec_ff        <= rec_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sample      = rsp_sample_ff;
   assign rsp_chan.out_channel = rsp_ch_ff;
   assign rsp_chan.last        = rsp_last_ff;

   a_tap_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_MUL |-> tap_ff == '0)
      else $error("tap counter not parked outside multiply passes");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> idx_ff < n_ff)
      else $error("sample index beyond slice count");

   a_emit_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> $past(state_ff) == ST_SUM || $past(state_ff) == ST_EMIT)
      else $error("clamp step entered without a finished sum");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE && last_sample |=> state_ff == ST_IDLE)
      else $error("decoder did not return to idle after final sample");

   a_load_last: assert property (@(posedge clock) disable iff (reset)
      rsp_load && last_sample |=> rsp_last_ff)
      else $error("final sample transfer not flagged last");

endmodule

`default_nettype wire
